[rtl/core/vdp_pkg.sv]
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared types, field widths and the step program of the Van der Pol stepper.
// ----------------------------------------------------------------------------
package vdp_pkg;

	// Widths of the stream fields
	localparam int FIELD_W     = 32;
	localparam int DT_W        = 19;
	localparam int DAMP_W      = 21;
	localparam int S_TDATA_W   = 88;
	localparam int M_TDATA_W   = 64;
	localparam int QDEPTH      = 2;

	localparam logic [DAMP_W-1:0] DAMPING_RESET = 21'd327680;

	// Item kinds carried on s_tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Micro-operations of the step program
	typedef enum logic [1:0] {
		UOP_ADD,
		UOP_SUB,
		UOP_MUL,
		UOP_MULH
	} uop_code_t;

	// Operand and destination registers of the back end
	typedef enum logic [3:0] {
		R_X,
		R_V,
		R_ALPHA,
		R_DT,
		R_ONE,
		R_T,
		R_K1V,
		R_K2X,
		R_XP,
		R_K2V
	} reg_sel_t;

	typedef struct packed {
		uop_code_t code;
		reg_sel_t  src_a;
		reg_sel_t  src_b;
		reg_sel_t  dst;
	} uop_t;

	typedef logic [4:0] pc_t;
	localparam pc_t PROG_LAST = 5'd19;

	// Head of the command queue
	typedef struct packed {
		logic valid;
		logic is_step;
		logic load_ovf;
	} head_t;

	// Multiplier handshake
	typedef struct packed {
		logic start;
		logic half;
	} mul_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mul_sts_t;

	// One Heun step: k1 from (x, v), predictor xp, k2 from (xp, k2x), then
	// the trapezoid update of x and v.
	function automatic uop_t micro_op(input pc_t pc);
		unique case (pc)
			5'd0:    return '{UOP_MUL,  R_X,     R_X,   R_T};
			5'd1:    return '{UOP_SUB,  R_ONE,   R_T,   R_T};
			5'd2:    return '{UOP_MUL,  R_ALPHA, R_T,   R_T};
			5'd3:    return '{UOP_MUL,  R_T,     R_V,   R_T};
			5'd4:    return '{UOP_SUB,  R_T,     R_X,   R_K1V};
			5'd5:    return '{UOP_MUL,  R_DT,    R_K1V, R_T};
			5'd6:    return '{UOP_ADD,  R_V,     R_T,   R_K2X};
			5'd7:    return '{UOP_MUL,  R_DT,    R_V,   R_T};
			5'd8:    return '{UOP_ADD,  R_X,     R_T,   R_XP};
			5'd9:    return '{UOP_MUL,  R_XP,    R_XP,  R_T};
			5'd10:   return '{UOP_SUB,  R_ONE,   R_T,   R_T};
			5'd11:   return '{UOP_MUL,  R_ALPHA, R_T,   R_T};
			5'd12:   return '{UOP_MUL,  R_T,     R_K2X, R_T};
			5'd13:   return '{UOP_SUB,  R_T,     R_XP,  R_K2V};
			5'd14:   return '{UOP_ADD,  R_V,     R_K2X, R_T};
			5'd15:   return '{UOP_MULH, R_DT,    R_T,   R_T};
			5'd16:   return '{UOP_ADD,  R_X,     R_T,   R_X};
			5'd17:   return '{UOP_ADD,  R_K1V,   R_K2V, R_T};
			5'd18:   return '{UOP_MULH, R_DT,    R_T,   R_T};
			5'd19:   return '{UOP_ADD,  R_V,     R_T,   R_V};
			default: return '{UOP_ADD,  R_T,     R_T,   R_T};
		endcase
	endfunction

endpackage

[rtl/core/vdp_front.sv]
// ----------------------------------------------------------------------------
// vdp_front
// Accepts items, classifies load or step, fits load values to the word and
// holds the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vdp_front #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [vdp_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	output vdp_pkg::head_t                  head,
	output logic [WORD_WIDTH-1:0]           head_pos,
	output logic [WORD_WIDTH-1:0]           head_vel,
	output logic [vdp_pkg::DT_W-1:0]        head_dt,
	input  logic                            pop
);

	localparam int FW    = vdp_pkg::FIELD_W;
	localparam int EXT_W = (WORD_WIDTH > FW) ? WORD_WIDTH : FW;
	localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic [1:0] FULL = 2'(vdp_pkg::QDEPTH);

	// Sign-extend a 32-bit field and saturate it to the word: {ovf, word}
	function automatic logic [WORD_WIDTH:0] fit_word(input logic [FW-1:0] val);
		logic [EXT_W-1:0]            ext;
		logic [EXT_W-WORD_WIDTH:0]   top_bits;
		ext      = EXT_W'(signed'(val));
		top_bits = ext[EXT_W-1:WORD_WIDTH-1];
		if (top_bits == '0 || top_bits == '1) begin
			return {1'b0, ext[WORD_WIDTH-1:0]};
		end
		return {1'b1, ext[EXT_W-1] ? W_MIN : W_MAX};
	endfunction

	logic [WORD_WIDTH:0]     pos_fit;
	logic [WORD_WIDTH:0]     vel_fit;
	logic                    is_step;
	logic                    push;

	logic [WORD_WIDTH-1:0]   pos_mem [vdp_pkg::QDEPTH];
	logic [WORD_WIDTH-1:0]   vel_mem [vdp_pkg::QDEPTH];
	logic [vdp_pkg::DT_W-1:0] dt_mem [vdp_pkg::QDEPTH];
	logic                    step_mem [vdp_pkg::QDEPTH];
	logic                    ovf_mem [vdp_pkg::QDEPTH];
	logic                    wr_q;
	logic                    rd_q;
	logic [1:0]              count_q;

	assign is_step  = (s_tuser == vdp_pkg::CMD_STEP);
	assign pos_fit  = fit_word(s_tdata[FW-1:0]);
	assign vel_fit  = fit_word(s_tdata[2*FW-1:FW]);
	assign s_tready = (count_q != FULL);
	assign push     = s_tvalid && s_tready;

	assign head.valid    = (count_q != 2'd0);
	assign head.is_step  = step_mem[rd_q];
	assign head.load_ovf = ovf_mem[rd_q];
	assign head_pos      = pos_mem[rd_q];
	assign head_vel      = vel_mem[rd_q];
	assign head_dt       = dt_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			pos_mem[wr_q]  <= pos_fit[WORD_WIDTH-1:0];
			vel_mem[wr_q]  <= vel_fit[WORD_WIDTH-1:0];
			dt_mem[wr_q]   <= s_tdata[2*FW+vdp_pkg::DT_W-1:2*FW];
			step_mem[wr_q] <= is_step;
			ovf_mem[wr_q]  <= !is_step && (pos_fit[WORD_WIDTH] || vel_fit[WORD_WIDTH]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/vdp_mul.sv]
// ----------------------------------------------------------------------------
// vdp_mul
// Shared fixed-point multiplier: four half-word partial products through one
// multiplier, then rounding shift and saturation to the word.
// ----------------------------------------------------------------------------
module vdp_mul #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vdp_pkg::mul_ctl_t     ctl,
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	output vdp_pkg::mul_sts_t     sts,
	output logic [WORD_WIDTH-1:0] result
);

	localparam int HALF_W = (WORD_WIDTH + 1) / 2;
	localparam int PART_W = 2 * HALF_W;
	localparam int PROD_W = 4 * HALF_W;
	localparam logic [PROD_W:0] RND_FULL = (PROD_W+1)'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << FRAC_BITS;
	localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic [2:0] PH_END = 3'd4;

	typedef enum logic [1:0] {
		M_IDLE,
		M_PP,
		M_RND,
		M_SAT
	} mstate_t;

	mstate_t               state_q;
	logic [PART_W-1:0]     ma_q;
	logic [PART_W-1:0]     mb_q;
	logic                  neg_q;
	logic                  half_q;
	logic [2:0]            ph_q;
	logic [PART_W-1:0]     pp_q;
	logic [1:0]            pp_sh_q;
	logic                  pp_vld_q;
	logic [PROD_W-1:0]     acc_q;
	logic [PROD_W:0]       q_q;
	logic [WORD_WIDTH-1:0] result_q;
	logic                  ovf_q;
	logic                  done_q;

	logic [WORD_WIDTH-1:0] a_mag;
	logic [WORD_WIDTH-1:0] b_mag;
	logic [HALF_W-1:0]     pa;
	logic [HALF_W-1:0]     pb;
	logic [PART_W-1:0]     pp_next;
	logic [PROD_W-1:0]     pp_wide;
	logic [PROD_W-1:0]     acc_next;
	logic [PROD_W:0]       rsum;
	logic [PROD_W:0]       q_next;
	logic [WORD_WIDTH-1:0] lo;
	logic [WORD_WIDTH-1:0] lim;
	logic                  sat;

	assign a_mag = a[WORD_WIDTH-1] ? -a : a;
	assign b_mag = b[WORD_WIDTH-1] ? -b : b;

	// Phase order: lo*lo, lo*hi, hi*lo, hi*hi
	assign pa      = ph_q[1] ? ma_q[PART_W-1:HALF_W] : ma_q[HALF_W-1:0];
	assign pb      = ph_q[0] ? mb_q[PART_W-1:HALF_W] : mb_q[HALF_W-1:0];
	assign pp_next = pa * pb;
	assign pp_wide = PROD_W'(pp_q);

	always_comb begin
		unique case (pp_sh_q)
			2'd0:    acc_next = acc_q + pp_wide;
			2'd3:    acc_next = acc_q + (pp_wide << PART_W);
			default: acc_next = acc_q + (pp_wide << HALF_W);
		endcase
	end

	assign rsum   = {1'b0, acc_q} + (half_q ? RND_HALF : RND_FULL);
	assign q_next = half_q ? (rsum >> (FRAC_BITS + 1)) : (rsum >> FRAC_BITS);

	assign lo  = q_q[WORD_WIDTH-1:0];
	assign lim = neg_q ? W_MIN : W_MAX;
	assign sat = (|q_q[PROD_W:WORD_WIDTH]) || (lo > lim);

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign result   = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			ma_q     <= '0;
			mb_q     <= '0;
			neg_q    <= 1'b0;
			half_q   <= 1'b0;
			ph_q     <= '0;
			pp_q     <= '0;
			pp_sh_q  <= '0;
			pp_vld_q <= 1'b0;
			acc_q    <= '0;
			q_q      <= '0;
			result_q <= '0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == M_SAT);
			unique case (state_q)
				M_IDLE: begin
					if (ctl.start) begin
						ma_q     <= PART_W'(a_mag);
						mb_q     <= PART_W'(b_mag);
						neg_q    <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
						half_q   <= ctl.half;
						ph_q     <= '0;
						pp_vld_q <= 1'b0;
						acc_q    <= '0;
						state_q  <= M_PP;
					end
				end
				M_PP: begin
					if (ph_q != PH_END) begin
						pp_q    <= pp_next;
						pp_sh_q <= ph_q[1:0];
					end
					pp_vld_q <= (ph_q != PH_END);
					if (pp_vld_q) begin
						acc_q <= acc_next;
					end
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_END) begin
						state_q <= M_RND;
					end
				end
				M_RND: begin
					q_q     <= q_next;
					state_q <= M_SAT;
				end
				M_SAT: begin
					if (sat) begin
						result_q <= neg_q ? W_MIN : W_MAX;
					end else begin
						result_q <= neg_q ? -lo : lo;
					end
					ovf_q   <= sat;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/vdp_back.sv]
// ----------------------------------------------------------------------------
// vdp_back
// Runs queued commands: a load sets the state, a step walks the Heun program
// through the shared multiplier and a saturating adder. Holds the result.
// ----------------------------------------------------------------------------
module vdp_back #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [vdp_pkg::DAMP_W-1:0]    damping,
	input  vdp_pkg::head_t                head,
	input  logic [WORD_WIDTH-1:0]         head_pos,
	input  logic [WORD_WIDTH-1:0]         head_vel,
	input  logic [vdp_pkg::DT_W-1:0]      head_dt,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vdp_pkg::FIELD_W-1:0]   position_out,
	output logic [vdp_pkg::FIELD_W-1:0]   velocity_out,
	output logic                          overflow
);

	localparam int FW    = vdp_pkg::FIELD_W;
	localparam int EXT_W = (WORD_WIDTH > FW) ? WORD_WIDTH : FW;
	localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic [WORD_WIDTH-1:0] ONE =
		(FRAC_BITS >= WORD_WIDTH - 1) ? W_MAX : (WORD_WIDTH'(1) << FRAC_BITS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_DONE
	} state_t;

	// Exact add or subtract, saturated: {ovf, word}
	function automatic logic [WORD_WIDTH:0] add_sat(input logic [WORD_WIDTH-1:0] x,
			input logic [WORD_WIDTH-1:0] y, input logic sub);
		logic [WORD_WIDTH:0] s;
		s = sub ? ({x[WORD_WIDTH-1], x} - {y[WORD_WIDTH-1], y})
		        : ({x[WORD_WIDTH-1], x} + {y[WORD_WIDTH-1], y});
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
			return {1'b1, s[WORD_WIDTH] ? W_MIN : W_MAX};
		end
		return {1'b0, s[WORD_WIDTH-1:0]};
	endfunction

	// Low 32 bits of the sign-extended word
	function automatic logic [FW-1:0] to_field(input logic [WORD_WIDTH-1:0] w);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(signed'(w));
		return ext[FW-1:0];
	endfunction

	state_t                   state_q;
	vdp_pkg::pc_t             pc_q;
	logic [WORD_WIDTH-1:0]    x_q;
	logic [WORD_WIDTH-1:0]    v_q;
	logic [WORD_WIDTH-1:0]    t_q;
	logic [WORD_WIDTH-1:0]    k1v_q;
	logic [WORD_WIDTH-1:0]    k2x_q;
	logic [WORD_WIDTH-1:0]    xp_q;
	logic [WORD_WIDTH-1:0]    k2v_q;
	logic [vdp_pkg::DT_W-1:0] dt_q;
	logic                     ovf_q;
	logic                     m_tvalid_q;
	logic [FW-1:0]            pos_out_q;
	logic [FW-1:0]            vel_out_q;
	logic                     ovf_out_q;

	vdp_pkg::uop_t            uop;
	logic [WORD_WIDTH-1:0]    opa;
	logic [WORD_WIDTH-1:0]    opb;
	logic [WORD_WIDTH:0]      alu;
	logic                     is_mul;
	vdp_pkg::mul_ctl_t        mul_ctl;
	vdp_pkg::mul_sts_t        mul_sts;
	logic [WORD_WIDTH-1:0]    mul_res;
	logic                     wr_en;
	logic [WORD_WIDTH-1:0]    wr_val;
	logic                     wr_ovf;

	assign uop = vdp_pkg::micro_op(pc_q);

	always_comb begin
		unique case (uop.src_a)
			vdp_pkg::R_X:     opa = x_q;
			vdp_pkg::R_V:     opa = v_q;
			vdp_pkg::R_ALPHA: opa = WORD_WIDTH'(damping);
			vdp_pkg::R_DT:    opa = WORD_WIDTH'(dt_q);
			vdp_pkg::R_ONE:   opa = ONE;
			vdp_pkg::R_T:     opa = t_q;
			vdp_pkg::R_K1V:   opa = k1v_q;
			vdp_pkg::R_K2X:   opa = k2x_q;
			vdp_pkg::R_XP:    opa = xp_q;
			vdp_pkg::R_K2V:   opa = k2v_q;
			default:          opa = t_q;
		endcase
		unique case (uop.src_b)
			vdp_pkg::R_X:     opb = x_q;
			vdp_pkg::R_V:     opb = v_q;
			vdp_pkg::R_ALPHA: opb = WORD_WIDTH'(damping);
			vdp_pkg::R_DT:    opb = WORD_WIDTH'(dt_q);
			vdp_pkg::R_ONE:   opb = ONE;
			vdp_pkg::R_T:     opb = t_q;
			vdp_pkg::R_K1V:   opb = k1v_q;
			vdp_pkg::R_K2X:   opb = k2x_q;
			vdp_pkg::R_XP:    opb = xp_q;
			vdp_pkg::R_K2V:   opb = k2v_q;
			default:          opb = t_q;
		endcase
	end

	assign alu    = add_sat(opa, opb, uop.code == vdp_pkg::UOP_SUB);
	assign is_mul = (uop.code == vdp_pkg::UOP_MUL) || (uop.code == vdp_pkg::UOP_MULH);

	assign mul_ctl.start = (state_q == S_ISSUE) && is_mul;
	assign mul_ctl.half  = (uop.code == vdp_pkg::UOP_MULH);

	assign wr_en  = ((state_q == S_ISSUE) && !is_mul) || ((state_q == S_WAIT) && mul_sts.done);
	assign wr_val = (state_q == S_WAIT) ? mul_res : alu[WORD_WIDTH-1:0];
	assign wr_ovf = (state_q == S_WAIT) ? mul_sts.ovf : alu[WORD_WIDTH];

	assign pop          = (state_q == S_IDLE) && head.valid;
	assign m_tvalid     = m_tvalid_q;
	assign position_out = pos_out_q;
	assign velocity_out = vel_out_q;
	assign overflow     = ovf_out_q;

	vdp_mul #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (opa),
		.b      (opb),
		.sts    (mul_sts),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			x_q        <= '0;
			v_q        <= '0;
			t_q        <= '0;
			k1v_q      <= '0;
			k2x_q      <= '0;
			xp_q       <= '0;
			k2v_q      <= '0;
			dt_q       <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			pos_out_q  <= '0;
			vel_out_q  <= '0;
			ovf_out_q  <= 1'b0;
		end else begin
			// S_DONE reloads the result register itself
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			if (wr_en) begin
				ovf_q <= ovf_q | wr_ovf;
				unique case (uop.dst)
					vdp_pkg::R_X:   x_q   <= wr_val;
					vdp_pkg::R_V:   v_q   <= wr_val;
					vdp_pkg::R_T:   t_q   <= wr_val;
					vdp_pkg::R_K1V: k1v_q <= wr_val;
					vdp_pkg::R_K2X: k2x_q <= wr_val;
					vdp_pkg::R_XP:  xp_q  <= wr_val;
					vdp_pkg::R_K2V: k2v_q <= wr_val;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						if (head.is_step) begin
							dt_q    <= head_dt;
							ovf_q   <= 1'b0;
							pc_q    <= '0;
							state_q <= S_ISSUE;
						end else begin
							x_q     <= head_pos;
							v_q     <= head_vel;
							ovf_q   <= head.load_ovf;
							state_q <= S_DONE;
						end
					end
				end
				S_ISSUE: begin
					if (is_mul) begin
						state_q <= S_WAIT;
					end else if (pc_q == vdp_pkg::PROG_LAST) begin
						state_q <= S_DONE;
					end else begin
						pc_q <= pc_q + 5'd1;
					end
				end
				S_WAIT: begin
					if (mul_sts.done) begin
						if (pc_q == vdp_pkg::PROG_LAST) begin
							state_q <= S_DONE;
						end else begin
							pc_q    <= pc_q + 5'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						pos_out_q  <= to_field(x_q);
						vel_out_q  <= to_field(v_q);
						ovf_out_q  <= ovf_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/van_der_pol_rk2_step.sv]
// ----------------------------------------------------------------------------
// van_der_pol_rk2_step
// Van der Pol oscillator state with load and Heun (RK2) step items.
// ----------------------------------------------------------------------------
// Holds position x and velocity v of x'' = alpha*(1 - x*x)*x' - x in signed
// fixed point (WORD_WIDTH bits, FRAC_BITS fraction bits). A load item (s_tuser
// low) sets x and v; a step item (s_tuser high) advances them by one Heun step
// of size step_size using alpha from the damping register. Every item returns
// one result with the new x and v and a flag that is set when any value of
// that item saturated. In a step item, ten products run one after another
// through a single shared multiplier (four half-word partial products, a
// rounding shift and a saturation stage), interleaved with ten saturating
// adds, then the result is issued. Up to two items wait in the input queue
// while one is worked on and one result sits in the output register. Write
// damping only while no item is in flight.
module van_der_pol_rk2_step #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// damping register, alpha in the same fixed point
	input  logic                           damping_we,
	input  logic [vdp_pkg::DAMP_W-1:0]     damping_wdata,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// load_position [31:0], load_velocity [63:32], step_size [82:64], zero pad
	input  logic [vdp_pkg::S_TDATA_W-1:0]  s_tdata,
	// op: 0 load, 1 step
	input  logic                           s_tuser,
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// position_out [31:0], velocity_out [63:32]
	output logic [vdp_pkg::M_TDATA_W-1:0]  m_tdata,
	// overflow
	output logic                           m_tuser
);

	logic [vdp_pkg::DAMP_W-1:0]  damping_q;
	vdp_pkg::head_t              head;
	logic [WORD_WIDTH-1:0]       head_pos;
	logic [WORD_WIDTH-1:0]       head_vel;
	logic [vdp_pkg::DT_W-1:0]    head_dt;
	logic                        pop;
	logic [vdp_pkg::FIELD_W-1:0] position_out;
	logic [vdp_pkg::FIELD_W-1:0] velocity_out;

	// Hold alpha; reset to 5.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q <= vdp_pkg::DAMPING_RESET;
		end else if (damping_we) begin
			damping_q <= damping_wdata;
		end
	end

	// Front: accept, classify and queue items
	vdp_front #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.head_pos (head_pos),
		.head_vel (head_vel),
		.head_dt  (head_dt),
		.pop      (pop)
	);

	// Back: execute loads and steps, hold the result until taken
	vdp_back #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.damping      (damping_q),
		.head         (head),
		.head_pos     (head_pos),
		.head_vel     (head_vel),
		.head_dt      (head_dt),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.position_out (position_out),
		.velocity_out (velocity_out),
		.overflow     (m_tuser)
	);

	assign m_tdata = {velocity_out, position_out};

	// The back end never drains an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head.valid)
		else $error("queue popped while empty");

	// An item taken into an empty queue is at its head in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !head.valid) |=> head.valid)
		else $error("accepted item missing from queue head");

endmodule
